### sv/cube_map_face_select_assert.svh
// assertion macros used by the cube map face select top module
`ifndef CUBE_MAP_FACE_SELECT_ASSERT_SVH
`define CUBE_MAP_FACE_SELECT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CMFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CMFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cmfs_pkg.sv
// shared constants, types and face codes for the cube map face select block
package cmfs_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int COORD_BITS     = 16;

  // magnitude of a component fits COMPONENT_BITS unsigned bits
  localparam int MAG_BITS = COMPONENT_BITS;
  // numerators, denominator (2 ma) and remainders
  localparam int NUM_BITS = COMPONENT_BITS + 1;
  // signed width for sc + ma and ma - tc
  localparam int SUM_BITS = NUM_BITS + 1;

  localparam int IN_FIELD_BITS  = 3 * COMPONENT_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int FACE_BITS      = 3;
  localparam int OUT_FIELD_BITS = FACE_BITS + 2 * COORD_BITS + 1;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic [FACE_BITS-1:0] {
    FACE_NEG_X = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_Y = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Z = 3'd4,
    FACE_POS_Z = 3'd5
  } face_t;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] x;
    logic signed [COMPONENT_BITS-1:0] y;
    logic signed [COMPONENT_BITS-1:0] z;
    logic        [MAG_BITS-1:0]       ax;
    logic        [MAG_BITS-1:0]       ay;
    logic        [MAG_BITS-1:0]       az;
    logic                             zero;
  } abs_t;

  typedef struct packed {
    face_t                 face;
    logic                  zero;
    logic                  sat_u;
    logic                  sat_v;
    logic [NUM_BITS-1:0]   den;
    logic [NUM_BITS-1:0]   rem_u;
    logic [NUM_BITS-1:0]   rem_v;
    logic [COORD_BITS-1:0] q_u;
    logic [COORD_BITS-1:0] q_v;
  } div_t;

endpackage

### sv/cube_map_face_select.sv
// Cube map face select: takes one direction vector per beat and returns the
// cube face with coordinates u = (sc+ma)/(2ma) and v = (ma-tc)/(2ma) as
// unsigned Q0.16, truncated and saturated to all ones; an all-zero vector
// sets zero_vector with face 0 and both coordinates 0. A new beat can be taken
// every cycle while the output is not held by backpressure. The pipeline has one
// stage for the magnitudes, one for the face pick, one per quotient bit in the
// restoring divide pipeline, and the output register. Every stage holds its
// beat under backpressure and fills bubbles, so input beats keep flowing into
// empty stages while a result waits at the output.
module cube_map_face_select (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // dir_x, dir_y, dir_z
  input  logic [cmfs_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // face, coord_u, coord_v, zero_vector
  output logic [cmfs_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);

`include "cube_map_face_select_assert.svh"

  localparam int CB = cmfs_pkg::COMPONENT_BITS;
  localparam int QB = cmfs_pkg::COORD_BITS;

  logic           abs_valid;
  logic           abs_ready;
  cmfs_pkg::abs_t abs_data;

  logic [QB:0]    div_valid;
  logic [QB:0]    div_ready;
  cmfs_pkg::div_t div_pipe [QB+1];

  cmfs_pkg::div_t last;
  logic [QB-1:0]  coord_u;
  logic [QB-1:0]  coord_v;
  logic [cmfs_pkg::OUT_DATA_BITS-1:0] tdata_next;
  logic           out_ready;

  cmfs_abs_stage u_abs (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s_axis_tvalid),
    .up_ready (s_axis_tready),
    .dir_x    (s_axis_tdata[CB-1:0]),
    .dir_y    (s_axis_tdata[2*CB-1:CB]),
    .dir_z    (s_axis_tdata[3*CB-1:2*CB]),
    .dn_valid (abs_valid),
    .dn_ready (abs_ready),
    .dn_data  (abs_data)
  );

  cmfs_face_stage u_face (
    .clk      (clk),
    .rst      (rst),
    .up_valid (abs_valid),
    .up_ready (abs_ready),
    .up_data  (abs_data),
    .dn_valid (div_valid[0]),
    .dn_ready (div_ready[0]),
    .dn_data  (div_pipe[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_div
    cmfs_div_stage u_div (
      .clk      (clk),
      .rst      (rst),
      .up_valid (div_valid[i]),
      .up_ready (div_ready[i]),
      .up_data  (div_pipe[i]),
      .dn_valid (div_valid[i+1]),
      .dn_ready (div_ready[i+1]),
      .dn_data  (div_pipe[i+1])
    );
  end

  assign last      = div_pipe[QB];
  assign out_ready = !m_axis_tvalid || m_axis_tready;
  assign div_ready[QB] = out_ready;

  assign coord_u = last.zero ? '0 : (last.sat_u ? '1 : last.q_u);
  assign coord_v = last.zero ? '0 : (last.sat_v ? '1 : last.q_v);

  always_comb begin
    tdata_next = '0;
    tdata_next[cmfs_pkg::OUT_FIELD_BITS-1:0] =
      {last.zero, coord_v, coord_u,
       last.zero ? cmfs_pkg::FACE_NEG_X : last.face};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_axis_tvalid <= div_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && div_valid[QB]) begin
      m_axis_tdata <= tdata_next;
    end
  end

  // zero vector beat carries face 0 and zero coordinates
  `CMFS_ASSERT_NOW(a_zero_result,
    m_axis_tvalid && m_axis_tdata[cmfs_pkg::OUT_FIELD_BITS-1],
    m_axis_tdata[cmfs_pkg::OUT_FIELD_BITS-2:0] == '0,
    "zero vector result not cleared")
  // an empty output register means the whole pipe can take a beat
  `CMFS_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready,
    "input stalled while output register is empty")
  // restoring divide keeps the remainder below the divisor
  `CMFS_ASSERT_NOW(a_rem_bound, div_valid[QB] && !last.zero,
    (last.rem_u < last.den) && (last.rem_v < last.den),
    "divide remainder out of range")
  // face code stays within the six faces
  `CMFS_ASSERT_NOW(a_face_range, m_axis_tvalid,
    m_axis_tdata[cmfs_pkg::FACE_BITS-1:0] <= cmfs_pkg::FACE_POS_Z,
    "face code out of range")

endmodule

### sv/cmfs_abs_stage.sv
// first stage: component magnitudes and zero vector detect
module cmfs_abs_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] dir_x,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] dir_y,
  input  logic signed [cmfs_pkg::COMPONENT_BITS-1:0] dir_z,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output cmfs_pkg::abs_t                   dn_data
);

  cmfs_pkg::abs_t data_next;
  logic signed [cmfs_pkg::COMPONENT_BITS:0] nx;
  logic signed [cmfs_pkg::COMPONENT_BITS:0] ny;
  logic signed [cmfs_pkg::COMPONENT_BITS:0] nz;

  assign up_ready = !dn_valid || dn_ready;

  // negate one bit wider so the most negative value stays exact
  assign nx = -{dir_x[cmfs_pkg::COMPONENT_BITS-1], dir_x};
  assign ny = -{dir_y[cmfs_pkg::COMPONENT_BITS-1], dir_y};
  assign nz = -{dir_z[cmfs_pkg::COMPONENT_BITS-1], dir_z};

  always_comb begin
    data_next.x    = dir_x;
    data_next.y    = dir_y;
    data_next.z    = dir_z;
    data_next.ax   = dir_x[cmfs_pkg::COMPONENT_BITS-1] ?
                     nx[cmfs_pkg::MAG_BITS-1:0] : cmfs_pkg::MAG_BITS'(dir_x);
    data_next.ay   = dir_y[cmfs_pkg::COMPONENT_BITS-1] ?
                     ny[cmfs_pkg::MAG_BITS-1:0] : cmfs_pkg::MAG_BITS'(dir_y);
    data_next.az   = dir_z[cmfs_pkg::COMPONENT_BITS-1] ?
                     nz[cmfs_pkg::MAG_BITS-1:0] : cmfs_pkg::MAG_BITS'(dir_z);
    data_next.zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

### sv/cmfs_face_stage.sv
// second stage: major axis pick, face code, numerators and denominator
module cmfs_face_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  cmfs_pkg::abs_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cmfs_pkg::div_t dn_data
);

  cmfs_pkg::div_t data_next;
  logic x_major;
  logic y_major;
  logic [cmfs_pkg::MAG_BITS-1:0] ma;
  logic signed [cmfs_pkg::SUM_BITS-1:0] xs;
  logic signed [cmfs_pkg::SUM_BITS-1:0] ys;
  logic signed [cmfs_pkg::SUM_BITS-1:0] zs;
  logic signed [cmfs_pkg::SUM_BITS-1:0] ma_s;
  logic signed [cmfs_pkg::SUM_BITS-1:0] sc;
  logic signed [cmfs_pkg::SUM_BITS-1:0] tc;
  logic signed [cmfs_pkg::SUM_BITS-1:0] num_u_w;
  logic signed [cmfs_pkg::SUM_BITS-1:0] num_v_w;
  logic [cmfs_pkg::NUM_BITS-1:0] num_u;
  logic [cmfs_pkg::NUM_BITS-1:0] num_v;
  logic [cmfs_pkg::NUM_BITS-1:0] den;
  cmfs_pkg::face_t face;

  assign up_ready = !dn_valid || dn_ready;

  assign xs   = cmfs_pkg::SUM_BITS'(up_data.x);
  assign ys   = cmfs_pkg::SUM_BITS'(up_data.y);
  assign zs   = cmfs_pkg::SUM_BITS'(up_data.z);

  // strict compares: a tie goes to z over y and to y over x
  assign x_major = (up_data.ax > up_data.ay) && (up_data.ax > up_data.az);
  assign y_major = up_data.ay > up_data.az;

  always_comb begin
    if (x_major) begin
      ma = up_data.ax;
      tc = -ys;
      if (!up_data.x[cmfs_pkg::COMPONENT_BITS-1] && up_data.x != '0) begin
        face = cmfs_pkg::FACE_POS_X;
        sc   = -zs;
      end else begin
        face = cmfs_pkg::FACE_NEG_X;
        sc   = zs;
      end
    end else if (y_major) begin
      ma = up_data.ay;
      sc = xs;
      if (!up_data.y[cmfs_pkg::COMPONENT_BITS-1] && up_data.y != '0) begin
        face = cmfs_pkg::FACE_POS_Y;
        tc   = zs;
      end else begin
        face = cmfs_pkg::FACE_NEG_Y;
        tc   = -zs;
      end
    end else begin
      ma = up_data.az;
      tc = -ys;
      if (!up_data.z[cmfs_pkg::COMPONENT_BITS-1] && up_data.z != '0) begin
        face = cmfs_pkg::FACE_POS_Z;
        sc   = xs;
      end else begin
        face = cmfs_pkg::FACE_NEG_Z;
        sc   = -xs;
      end
    end
  end

  assign ma_s    = signed'({{(cmfs_pkg::SUM_BITS-cmfs_pkg::MAG_BITS){1'b0}}, ma});
  assign num_u_w = sc + ma_s;
  assign num_v_w = ma_s - tc;
  assign num_u   = num_u_w[cmfs_pkg::NUM_BITS-1:0];
  assign num_v   = num_v_w[cmfs_pkg::NUM_BITS-1:0];
  assign den     = {ma, 1'b0};

  always_comb begin
    data_next.face  = face;
    data_next.zero  = up_data.zero;
    // a fraction of exactly one saturates, the divide then runs on zero
    data_next.sat_u = (num_u == den);
    data_next.sat_v = (num_v == den);
    data_next.den   = den;
    data_next.rem_u = (num_u == den) ? '0 : num_u;
    data_next.rem_v = (num_v == den) ? '0 : num_v;
    data_next.q_u   = '0;
    data_next.q_v   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

### sv/cmfs_div_stage.sv
// one restoring divide step: one quotient bit for both coordinates
module cmfs_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  cmfs_pkg::div_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cmfs_pkg::div_t dn_data
);

  cmfs_pkg::div_t data_next;
  logic [cmfs_pkg::NUM_BITS:0] den_w;
  logic [cmfs_pkg::NUM_BITS:0] tu;
  logic [cmfs_pkg::NUM_BITS:0] tv;
  logic [cmfs_pkg::NUM_BITS:0] du;
  logic [cmfs_pkg::NUM_BITS:0] dv;
  logic bit_u;
  logic bit_v;

  assign up_ready = !dn_valid || dn_ready;

  assign den_w = {1'b0, up_data.den};
  assign tu    = {up_data.rem_u, 1'b0};
  assign tv    = {up_data.rem_v, 1'b0};
  assign du    = tu - den_w;
  assign dv    = tv - den_w;
  assign bit_u = (tu >= den_w);
  assign bit_v = (tv >= den_w);

  always_comb begin
    data_next       = up_data;
    data_next.rem_u = bit_u ? du[cmfs_pkg::NUM_BITS-1:0] : tu[cmfs_pkg::NUM_BITS-1:0];
    data_next.rem_v = bit_v ? dv[cmfs_pkg::NUM_BITS-1:0] : tv[cmfs_pkg::NUM_BITS-1:0];
    data_next.q_u   = {up_data.q_u[cmfs_pkg::COORD_BITS-2:0], bit_u};
    data_next.q_v   = {up_data.q_v[cmfs_pkg::COORD_BITS-2:0], bit_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule
